// ===== rtl/lrucache_pkg.sv =====
package lrucache_pkg;

  localparam int CACHE_WAYS = 8;
  localparam int MEM_WORDS  = 1024;

  localparam int WAY_W      = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
  localparam int CNT_W      = $clog2(CACHE_WAYS + 1);
  localparam int ADDR_W     = $clog2(MEM_WORDS);
  localparam int CLR_W      = $clog2(MEM_WORDS + 1);
  localparam int DATA_W     = 32;
  localparam int WAYS_CFG_W = 4;
  localparam int WORDS_CFG_W = 11;
  localparam int CFG_DATA_W = WORDS_CFG_W;
  localparam int S_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;

  typedef enum logic {
    CFG_WAYS_IN_USE  = 1'b0,
    CFG_WORDS_IN_USE = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

endpackage

// ===== rtl/lru_cache_over_backing_memory.sv =====
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: address, write_data; s_tuser: cmd
// m_*       out  m_tvalid/m_tready    m_tdata: read_data; m_tuser: hit, status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// The backing memory is read in the accept cycle (ST_IDLE); the lookup, writeback
// of the victim and entry update happen in ST_EXEC.
// The single backing memory has one write and one read port.
// After rst the backing memory is cleared one word a cycle, all 1024 words, with
// s_tready low; config writes are taken throughout.
// A result waiting in the output register stalls only ST_EXEC, not the accept.
module lru_cache_over_backing_memory (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lrucache_pkg::S_TDATA_W-1:0] s_tdata,   // address, write_data, zero pad
  input  logic                              s_tuser,   // cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lrucache_pkg::DATA_W-1:0]    m_tdata,   // read_data
  output logic [1:0]                        m_tuser,   // hit, status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [lrucache_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  logic [lrucache_pkg::WAYS_CFG_W-1:0]  ways_in_use;
  logic [lrucache_pkg::WORDS_CFG_W-1:0] words_in_use;

  logic [lrucache_pkg::ADDR_W-1:0] entry_tag   [lrucache_pkg::CACHE_WAYS];
  logic [lrucache_pkg::DATA_W-1:0] entry_value [lrucache_pkg::CACHE_WAYS];
  logic [lrucache_pkg::WAY_W-1:0]  rank        [lrucache_pkg::CACHE_WAYS];
  logic [lrucache_pkg::WAY_W-1:0]  rank_next   [lrucache_pkg::CACHE_WAYS];
  logic [lrucache_pkg::CNT_W-1:0]  occ;

  logic [lrucache_pkg::DATA_W-1:0] mem [lrucache_pkg::MEM_WORDS];
  logic [lrucache_pkg::DATA_W-1:0] mem_rdata;
  logic                            mem_we;
  logic [lrucache_pkg::ADDR_W-1:0] mem_waddr;
  logic [lrucache_pkg::DATA_W-1:0] mem_wdata;
  logic [lrucache_pkg::CLR_W-1:0]  clear_cnt;
  logic                            clearing;

  logic                            cmd_q;
  logic [lrucache_pkg::ADDR_W-1:0] addr_q;
  logic [lrucache_pkg::DATA_W-1:0] wdata_q;

  logic [lrucache_pkg::CACHE_WAYS-1:0] occupied;
  logic [lrucache_pkg::CACHE_WAYS-1:0] hit_vec;
  logic                            hit;
  logic [lrucache_pkg::WAY_W-1:0]  hit_slot;
  logic [lrucache_pkg::WAY_W-1:0]  victim;
  logic [lrucache_pkg::WAY_W-1:0]  slot;
  logic [lrucache_pkg::WAY_W-1:0]  slot_rank;
  logic [lrucache_pkg::CNT_W-1:0]  lim_ways;
  logic                            full;
  logic                            err;
  logic                            fire;
  logic                            accept;

  assign clearing  = clear_cnt != lrucache_pkg::CLR_W'(lrucache_pkg::MEM_WORDS);
  assign s_tready  = (state == ST_IDLE) && !clearing;
  assign accept    = s_tvalid && s_tready;
  assign fire      = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;

  assign err = {1'b0, addr_q} >= words_in_use;

  always_comb begin
    if (ways_in_use == '0) begin
      lim_ways = lrucache_pkg::CNT_W'(1);
    end else if (int'(ways_in_use) > lrucache_pkg::CACHE_WAYS) begin
      lim_ways = lrucache_pkg::CNT_W'(lrucache_pkg::CACHE_WAYS);
    end else begin
      lim_ways = lrucache_pkg::CNT_W'(ways_in_use);
    end
  end

  assign full = occ >= lim_ways;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    victim   = '0;
    for (int i = 0; i < lrucache_pkg::CACHE_WAYS; i++) begin
      occupied[i] = i < int'(occ);
      hit_vec[i]  = occupied[i] && (entry_tag[i] == addr_q);
    end
    for (int i = lrucache_pkg::CACHE_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit      = 1'b1;
        hit_slot = lrucache_pkg::WAY_W'(i);
      end
      // ranks of occupied slots are a permutation of 0..occ-1
      if (occupied[i] && rank[i] == lrucache_pkg::WAY_W'(occ - 1'b1)) begin
        victim = lrucache_pkg::WAY_W'(i);
      end
    end
    if (hit) begin
      slot = hit_slot;
    end else if (full) begin
      slot = victim;
    end else begin
      slot = lrucache_pkg::WAY_W'(occ);
    end
    slot_rank = rank[slot];
    for (int i = 0; i < lrucache_pkg::CACHE_WAYS; i++) begin
      if (lrucache_pkg::WAY_W'(i) == slot) begin
        rank_next[i] = '0;
      end else if (occupied[i] && ((!hit && !full) || rank[i] < slot_rank)) begin
        rank_next[i] = rank[i] + 1'b1;
      end else begin
        rank_next[i] = rank[i];
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_cnt[lrucache_pkg::ADDR_W-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = fire && !err && !hit && full;
      mem_waddr = entry_tag[victim];
      mem_wdata = entry_value[victim];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= mem[s_tdata[lrucache_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use  <= lrucache_pkg::WAYS_CFG_W'(8);
      words_in_use <= lrucache_pkg::WORDS_CFG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrucache_pkg::CFG_WAYS_IN_USE: begin
          ways_in_use <= cfg_data[lrucache_pkg::WAYS_CFG_W-1:0];
        end
        lrucache_pkg::CFG_WORDS_IN_USE: begin
          words_in_use <= cfg_data[lrucache_pkg::WORDS_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= s_tuser;
      addr_q  <= s_tdata[lrucache_pkg::ADDR_W-1:0];
      wdata_q <= s_tdata[lrucache_pkg::ADDR_W +: lrucache_pkg::DATA_W];
    end
    if (fire && !err) begin
      if (!hit) begin
        entry_tag[slot] <= addr_q;
      end
      if (cmd_q == lrucache_pkg::CMD_WRITE) begin
        entry_value[slot] <= wdata_q;
      end else if (!hit) begin
        entry_value[slot] <= mem_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < lrucache_pkg::CACHE_WAYS; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && !fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
            if (err) begin
              m_tdata <= '0;
              m_tuser <= {lrucache_pkg::STATUS_RANGE, 1'b0};
            end else begin
              m_tdata <= hit ? entry_value[slot] : mem_rdata;
              m_tuser <= {lrucache_pkg::STATUS_OK, hit};
              for (int i = 0; i < lrucache_pkg::CACHE_WAYS; i++) begin
                rank[i] <= rank_next[i];
              end
              if (!hit && !full) begin
                occ <= occ + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input taken during memory clear");

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transfer taken before lookup finished");

  a_writeback_not_target: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |-> (mem_waddr != addr_q))
    else $error("victim writeback hits the missed address");

  a_range_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata == '0))
    else $error("range error result carries data or hit");

  a_occ_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    (occ != $past(occ)) |-> (occ == $past(occ) + 1'b1))
    else $error("occupancy changed by more than one");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    (fire && !err && !hit && !full) |-> (occ < lim_ways))
    else $error("fill beyond way limit");

endmodule
